// File: design/sdci_pkg.sv
// Shared types and constants for the SD card initialisation sequencer.
// No dependencies; imported by every module of the block.
package sdci_pkg;

    // Data block length expected after each CMD6, query and switch alike
    localparam logic [9:0] BLOCK_WORDS = 10'd128;

    // Result queue depth, in results
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_WIDE_BUS  = 2'd0;
    localparam logic [1:0] CFG_INIT_DIV  = 2'd1;
    localparam logic [1:0] CFG_RUN_DIV   = 2'd2;
    localparam logic [1:0] CFG_PU_TRIES  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [15:0] INIT_DIV_RST = 16'd199;
    localparam logic [15:0] RUN_DIV_RST  = 16'd1;
    localparam logic [7:0]  PU_TRIES_RST = 8'd20;

    // Event kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_RESP  = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;

    // Command arguments
    localparam logic [31:0] ARG_CMD8     = 32'h0000_01AA;
    localparam logic [31:0] ARG_ACMD41   = 32'h50FF_8000;
    localparam logic [31:0] ARG_CMD16    = 32'h0000_0200;
    localparam logic [31:0] ARG_Q6       = 32'h00FF_0001;
    localparam logic [31:0] ARG_S6       = 32'h80FF_0001;
    localparam logic [31:0] ARG_BUS_WIDE = 32'h0000_0002;
    localparam logic [3:0]  STATE_TRAN   = 4'd4;

    // Command numbers
    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_APP      = 6'd55;
    localparam logic [5:0] CMD_OP_COND  = 6'd41;
    localparam logic [5:0] CMD_ALL_CID  = 6'd2;
    localparam logic [5:0] CMD_REL_ADDR = 6'd3;
    localparam logic [5:0] CMD_SELECT   = 6'd7;
    localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_SWITCH   = 6'd6;

    // Sequence phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_CMD8  = 4'd1,
        PH_C55   = 4'd2,
        PH_A41   = 4'd3,
        PH_CMD2  = 4'd4,
        PH_CMD3  = 4'd5,
        PH_CMD7  = 4'd6,
        PH_CMD16 = 4'd7,
        PH_B55   = 4'd8,
        PH_A6    = 4'd9,
        PH_Q6    = 4'd10,
        PH_QDATA = 4'd11,
        PH_S6    = 4'd12,
        PH_SDATA = 4'd13
    } t_phase;

    // Completion status
    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_CMD8     = 4'd1,
        ST_ACMD41   = 4'd2,
        ST_POWERUP  = 4'd3,
        ST_CMD2     = 4'd4,
        ST_CMD3     = 4'd5,
        ST_CMD7     = 4'd6,
        ST_CMD16    = 4'd7,
        ST_NOT_TRAN = 4'd8,
        ST_ACMD6    = 4'd9,
        ST_CMD6     = 4'd10
    } t_status;

    // One result
    typedef struct packed {
        logic        cmd_valid;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_argument;
        logic        divider_write;
        logic [15:0] divider_value;
        logic        done_res;
        logic [3:0]  status;
        logic        ver2_card;
        logic        high_capacity;
        logic [15:0] card_address;
        logic        last;
    } t_result;

    // Card state carried between events
    typedef struct packed {
        t_phase      phase;
        logic [7:0]  try_count;
        logic [15:0] rca;
        logic        sd2;
        logic        capacity;
    } t_card_state;

    // Results of one event, pushed into the queue together
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // Build a command result; flags are filled in later
    function automatic t_result f_issue(logic [5:0] idx, logic [31:0] arg);
        t_result r;
        r              = '0;
        r.cmd_valid    = 1'b1;
        r.cmd_index    = idx;
        r.cmd_argument = arg;
        r.last         = 1'b1;
        return r;
    endfunction

    // Build a completion result; the run divider loads only on success
    function automatic t_result f_finish(t_status st, logic [15:0] run_div);
        t_result r;
        r               = '0;
        r.done_res      = 1'b1;
        r.status        = st;
        r.divider_write = (st == ST_OK);
        r.divider_value = (st == ST_OK) ? run_div : 16'd0;
        r.last          = 1'b1;
        return r;
    endfunction

endpackage

// File: design/sdci_step.sv
// Next-state and result logic for one event of the initialisation sequence.
// Depends on sdci_pkg.
module sdci_step import sdci_pkg::*; (
    input  t_card_state i_state,
    input  logic        i_wide_bus,
    input  logic [15:0] i_init_div,
    input  logic [15:0] i_run_div,
    input  logic [7:0]  i_pu_tries,
    input  logic [1:0]  i_kind,
    input  logic        i_resp_timeout,
    input  logic        i_resp_crc_error,
    input  logic [31:0] i_resp_word_low,
    input  logic [31:0] i_resp_word_high,
    input  logic [9:0]  i_block_word_count,
    output t_card_state o_state,
    output t_push       o_push
);

    logic        err;
    logic [7:0]  try_inc;
    logic [7:0]  try_lim;
    logic [15:0] rca_cap;
    t_card_state ns;
    t_push       p;

    assign err     = i_resp_timeout | i_resp_crc_error;
    assign try_inc = i_state.try_count + 8'd1;
    assign try_lim = (i_pu_tries == 8'd0) ? 8'd1 : i_pu_tries;
    assign rca_cap = i_resp_word_low[31:16] | {i_resp_word_high[7:0], 8'h00};

    // Pick the next command or completion for this event
    always_comb begin
        ns = i_state;
        p  = '0;
        case (i_kind)
            KIND_START: begin
                if (i_state.phase == PH_IDLE) begin
                    ns                     = '0;
                    ns.phase               = PH_CMD8;
                    p.count                = 2'd2;
                    p.res0                 = f_issue(CMD_GO_IDLE, 32'd0);
                    p.res0.divider_write   = 1'b1;
                    p.res0.divider_value   = i_init_div;
                    p.res0.last            = 1'b0;
                    p.res1                 = f_issue(CMD_IF_COND, ARG_CMD8);
                end
            end
            KIND_BLOCK: begin
                if (i_state.phase == PH_QDATA) begin
                    p.count = 2'd1;
                    if (i_block_word_count != BLOCK_WORDS) begin
                        ns.phase = PH_IDLE;
                        p.res0   = f_finish(ST_CMD6, i_run_div);
                    end else begin
                        ns.phase = PH_S6;
                        p.res0   = f_issue(CMD_SWITCH, ARG_S6);
                    end
                end else if (i_state.phase == PH_SDATA) begin
                    p.count  = 2'd1;
                    ns.phase = PH_IDLE;
                    p.res0   = f_finish((i_block_word_count != BLOCK_WORDS) ? ST_CMD6 : ST_OK,
                                        i_run_div);
                end
            end
            KIND_RESP: begin
                p.count = 2'd1;
                case (i_state.phase)
                    PH_CMD8: begin
                        if (i_resp_crc_error) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_CMD8, i_run_div);
                        end else begin
                            ns.sd2       = ~i_resp_timeout;
                            ns.try_count = 8'd0;
                            ns.phase     = PH_C55;
                            p.res0       = f_issue(CMD_APP, 32'd0);
                        end
                    end
                    PH_C55: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_ACMD41, i_run_div);
                        end else begin
                            ns.phase = PH_A41;
                            p.res0   = f_issue(CMD_OP_COND, ARG_ACMD41);
                        end
                    end
                    PH_A41: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_ACMD41, i_run_div);
                        end else if (i_resp_word_high[7]) begin
                            ns.capacity = i_resp_word_high[6];
                            ns.phase    = PH_CMD2;
                            p.res0      = f_issue(CMD_ALL_CID, 32'd0);
                        end else begin
                            ns.try_count = try_inc;
                            if (try_inc >= try_lim) begin
                                ns.phase = PH_IDLE;
                                p.res0   = f_finish(ST_POWERUP, i_run_div);
                            end else begin
                                ns.phase = PH_C55;
                                p.res0   = f_issue(CMD_APP, 32'd0);
                            end
                        end
                    end
                    PH_CMD2: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_CMD2, i_run_div);
                        end else begin
                            ns.phase = PH_CMD3;
                            p.res0   = f_issue(CMD_REL_ADDR, 32'd0);
                        end
                    end
                    PH_CMD3: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_CMD3, i_run_div);
                        end else begin
                            ns.rca   = rca_cap;
                            ns.phase = PH_CMD7;
                            p.res0   = f_issue(CMD_SELECT, {rca_cap, 16'd0});
                        end
                    end
                    PH_CMD7: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_CMD7, i_run_div);
                        end else begin
                            ns.phase = PH_CMD16;
                            p.res0   = f_issue(CMD_BLOCKLEN, ARG_CMD16);
                        end
                    end
                    PH_CMD16: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_CMD16, i_run_div);
                        end else if (i_resp_word_low[12:9] != STATE_TRAN) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_NOT_TRAN, i_run_div);
                        end else begin
                            ns.phase = PH_B55;
                            p.res0   = f_issue(CMD_APP, {i_state.rca, 16'd0});
                        end
                    end
                    PH_B55: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_ACMD6, i_run_div);
                        end else begin
                            ns.phase = PH_A6;
                            p.res0   = f_issue(CMD_SWITCH, i_wide_bus ? ARG_BUS_WIDE : 32'd0);
                        end
                    end
                    PH_A6: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_ACMD6, i_run_div);
                        end else begin
                            ns.phase = PH_Q6;
                            p.res0   = f_issue(CMD_SWITCH, ARG_Q6);
                        end
                    end
                    PH_Q6, PH_S6: begin
                        if (err) begin
                            ns.phase = PH_IDLE;
                            p.res0   = f_finish(ST_CMD6, i_run_div);
                        end else begin
                            // wait for the data block, no result
                            ns.phase = (i_state.phase == PH_Q6) ? PH_QDATA : PH_SDATA;
                            p.count  = 2'd0;
                        end
                    end
                    default: begin
                        p.count = 2'd0;
                    end
                endcase
            end
            default: begin
                p.count = 2'd0;
            end
        endcase

        // Every result carries the card flags as left by this event
        p.res0.ver2_card     = ns.sd2;
        p.res0.high_capacity = ns.capacity;
        p.res0.card_address  = ns.rca;
        p.res1.ver2_card     = ns.sd2;
        p.res1.high_capacity = ns.capacity;
        p.res1.card_address  = ns.rca;
    end

    assign o_state = ns;
    assign o_push  = p;

endmodule

// File: design/sdci_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transaction.
// Depends on sdci_pkg.
module sdci_result_fifo import sdci_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_head
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_AW-1:0]   wr_next;
    logic                 pop_ok;

    assign wr_next = r_wr + FIFO_AW'(1);
    assign pop_ok  = i_pop && (r_count != '0);

    // Room for a full two-result run
    assign o_space = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    // Hold pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push.count);
            r_rd    <= r_rd + FIFO_AW'(pop_ok);
            r_count <= r_count + FIFO_CW'(i_push.count) - FIFO_CW'(pop_ok);
        end
    end

    // Store the pushed results
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

endmodule

// File: design/sd_card_init_sequencer.sv
// SD card initialisation sequencer, top level.
// An event's first result is offered once the event has passed the input register and been
// written into the result queue. Throughput: one event per cycle while the queue has room for
// two more results; otherwise o_in_stall holds the events. A start event yields two results.
// Reset (synchronous, active low): phase idle, card state cleared, queue empty,
// configuration registers back to their defaults.
module sd_card_init_sequencer import sdci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // events
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic        i_resp_timeout,
    input  logic        i_resp_crc_error,
    input  logic [31:0] i_resp_word_low,
    input  logic [31:0] i_resp_word_high,
    input  logic [9:0]  i_block_word_count,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_cmd_valid,
    output logic [5:0]  o_cmd_index,
    output logic [31:0] o_cmd_argument,
    output logic        o_divider_write,
    output logic [15:0] o_divider_value,
    output logic        o_done_res,
    output logic [3:0]  o_status,
    output logic        o_ver2_card,
    output logic        o_high_capacity,
    output logic [15:0] o_card_address,
    output logic        o_last
);

    logic        r_wide_bus;
    logic [15:0] r_init_div;
    logic [15:0] r_run_div;
    logic [7:0]  r_pu_tries;

    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic        r_timeout;
    logic        r_crc_error;
    logic [31:0] r_word_low;
    logic [31:0] r_word_high;
    logic [9:0]  r_block_count;

    t_card_state r_state;
    t_card_state n_state;
    t_push       step_push;
    t_push       push;
    logic        space;
    logic        in_take;
    t_result     head;

    assign in_take    = r_in_valid && space;
    assign o_in_stall = r_in_valid && !space;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_bus <= 1'b0;
            r_init_div <= INIT_DIV_RST;
            r_run_div  <= RUN_DIV_RST;
            r_pu_tries <= PU_TRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDE_BUS: r_wide_bus <= i_cfg_data[0];
                CFG_INIT_DIV: r_init_div <= i_cfg_data;
                CFG_RUN_DIV:  r_run_div  <= i_cfg_data;
                CFG_PU_TRIES: r_pu_tries <= i_cfg_data[7:0];
                default:      r_wide_bus <= r_wide_bus;
            endcase
        end
    end

    // Input register: advance when empty or being processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind        <= i_kind;
            r_timeout     <= i_resp_timeout;
            r_crc_error   <= i_resp_crc_error;
            r_word_low    <= i_resp_word_low;
            r_word_high   <= i_resp_word_high;
            r_block_count <= i_block_word_count;
        end
    end

    sdci_step u_step (
        .i_state            (r_state),
        .i_wide_bus         (r_wide_bus),
        .i_init_div         (r_init_div),
        .i_run_div          (r_run_div),
        .i_pu_tries         (r_pu_tries),
        .i_kind             (r_kind),
        .i_resp_timeout     (r_timeout),
        .i_resp_crc_error   (r_crc_error),
        .i_resp_word_low    (r_word_low),
        .i_resp_word_high   (r_word_high),
        .i_block_word_count (r_block_count),
        .o_state            (n_state),
        .o_push             (step_push)
    );

    // Drop the step's results unless the event is processed this cycle
    always_comb begin
        push = step_push;
        if (!in_take) begin
            push.count = 2'd0;
        end
    end

    // Card state; all-zero is the idle phase with flags cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    sdci_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_space (space),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_cmd_valid     = head.cmd_valid;
    assign o_cmd_index     = head.cmd_index;
    assign o_cmd_argument  = head.cmd_argument;
    assign o_divider_write = head.divider_write;
    assign o_divider_value = head.divider_value;
    assign o_done_res      = head.done_res;
    assign o_status        = head.status;
    assign o_ver2_card     = head.ver2_card;
    assign o_high_capacity = head.high_capacity;
    assign o_card_address  = head.card_address;
    assign o_last          = head.last;

endmodule

// File: verif/sd_card_init_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the SD card initialisation sequencer.
// Drives card bring-up event streams, predicts every result and checks each one.
// Depends on sdci_pkg and sd_card_init_sequencer from the design folder.
module sd_card_init_sequencer_tb;
    import sdci_pkg::*;

    // Event kind the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic        tmo;
        logic        crc;
        logic [31:0] wlo;
        logic [31:0] whi;
        logic [9:0]  cnt;
    } t_event;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_cfg_we           = 1'b0;
    logic [1:0]  i_cfg_index        = CFG_WIDE_BUS;
    logic [15:0] i_cfg_data         = 16'd0;
    logic        i_in_valid         = 1'b0;
    logic [1:0]  i_kind             = KIND_START;
    logic        i_resp_timeout     = 1'b0;
    logic        i_resp_crc_error   = 1'b0;
    logic [31:0] i_resp_word_low    = 32'd0;
    logic [31:0] i_resp_word_high   = 32'd0;
    logic [9:0]  i_block_word_count = 10'd0;
    logic        i_out_stall        = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_cmd_valid;
    logic [5:0]  o_cmd_index;
    logic [31:0] o_cmd_argument;
    logic        o_divider_write;
    logic [15:0] o_divider_value;
    logic        o_done_res;
    logic [3:0]  o_status;
    logic        o_ver2_card;
    logic        o_high_capacity;
    logic [15:0] o_card_address;
    logic        o_last;

    sd_card_init_sequencer dut (.*);

    // Stimulus bookkeeping
    t_event  pending[$];
    t_result results_due[$];
    int      items_left     = 0;
    int      items_queued   = 0;
    int      mismatch_count = 0;
    int      send_gap_pct   = 15;
    int      recv_gap_pct   = 69;
    logic    hold_send      = 1'b0;
    logic    ev_taken       = 1'b0;

    // Predicted card state and configuration
    t_phase      ph           = PH_IDLE;
    logic [7:0]  try_total    = 8'd0;
    logic [15:0] rca          = 16'd0;
    logic        sd2          = 1'b0;
    logic        hcap         = 1'b0;
    logic        wide_cfg     = 1'b0;
    logic [15:0] init_div_cfg = INIT_DIV_RST;
    logic [15:0] run_div_cfg  = RUN_DIV_RST;
    logic [7:0]  tries_cfg    = PU_TRIES_RST;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // ---------------------------------------------------------------- prediction

    // Append one expected result, carrying the card flags as they stand now
    task automatic queue_result(logic cv, logic [5:0] idx, logic [31:0] arg, logic dw,
                                logic [15:0] dv, logic dn, logic [3:0] st, logic lst);
        t_result r;
        r.cmd_valid     = cv;
        r.cmd_index     = idx;
        r.cmd_argument  = arg;
        r.divider_write = dw;
        r.divider_value = dv;
        r.done_res      = dn;
        r.status        = st;
        r.ver2_card     = sd2;
        r.high_capacity = hcap;
        r.card_address  = rca;
        r.last          = lst;
        results_due.push_back(r);
    endtask

    task automatic next_cmd(logic [5:0] idx, logic [31:0] arg, t_phase nxt);
        ph = nxt;
        queue_result(1'b1, idx, arg, 1'b0, 16'd0, 1'b0, ST_OK, 1'b1);
    endtask

    // Close the sequence; the run divider loads only on success
    task automatic end_sequence(t_status st);
        ph = PH_IDLE;
        queue_result(1'b0, 6'd0, 32'd0, st == ST_OK, (st == ST_OK) ? run_div_cfg : 16'd0,
                     1'b1, st, 1'b1);
    endtask

    // Advance the predicted sequencer by one accepted event
    task automatic sequence_step(t_event e);
        logic       err;
        logic [7:0] lim;
        err = e.tmo | e.crc;
        lim = (tries_cfg == 8'd0) ? 8'd1 : tries_cfg;
        case (e.kind)
            KIND_START: begin
                if (ph == PH_IDLE) begin
                    try_total = 8'd0;
                    rca       = 16'd0;
                    sd2       = 1'b0;
                    hcap      = 1'b0;
                    ph        = PH_CMD8;
                    queue_result(1'b1, CMD_GO_IDLE, 32'd0, 1'b1, init_div_cfg, 1'b0, ST_OK,
                                 1'b0);
                    queue_result(1'b1, CMD_IF_COND, ARG_CMD8, 1'b0, 16'd0, 1'b0, ST_OK, 1'b1);
                end
            end
            KIND_BLOCK: begin
                if (ph == PH_QDATA || ph == PH_SDATA) begin
                    if (e.cnt != BLOCK_WORDS)
                        end_sequence(ST_CMD6);
                    else if (ph == PH_QDATA)
                        next_cmd(CMD_SWITCH, ARG_S6, PH_S6);
                    else
                        end_sequence(ST_OK);
                end
            end
            KIND_RESP: begin
                case (ph)
                    PH_CMD8: begin
                        if (e.crc) begin
                            end_sequence(ST_CMD8);
                        end else begin
                            // a bare timeout means a version 1 card
                            sd2       = ~e.tmo;
                            try_total = 8'd0;
                            next_cmd(CMD_APP, 32'd0, PH_C55);
                        end
                    end
                    PH_C55: begin
                        if (err) end_sequence(ST_ACMD41);
                        else     next_cmd(CMD_OP_COND, ARG_ACMD41, PH_A41);
                    end
                    PH_A41: begin
                        if (err) begin
                            end_sequence(ST_ACMD41);
                        end else if (e.whi[7]) begin
                            hcap = e.whi[6];
                            next_cmd(CMD_ALL_CID, 32'd0, PH_CMD2);
                        end else begin
                            try_total = try_total + 8'd1;
                            if (try_total >= lim) end_sequence(ST_POWERUP);
                            else                  next_cmd(CMD_APP, 32'd0, PH_C55);
                        end
                    end
                    PH_CMD2: begin
                        if (err) end_sequence(ST_CMD2);
                        else     next_cmd(CMD_REL_ADDR, 32'd0, PH_CMD3);
                    end
                    PH_CMD3: begin
                        if (err) begin
                            end_sequence(ST_CMD3);
                        end else begin
                            rca = e.wlo[31:16] | {e.whi[7:0], 8'h00};
                            next_cmd(CMD_SELECT, {rca, 16'h0000}, PH_CMD7);
                        end
                    end
                    PH_CMD7: begin
                        if (err) end_sequence(ST_CMD7);
                        else     next_cmd(CMD_BLOCKLEN, ARG_CMD16, PH_CMD16);
                    end
                    PH_CMD16: begin
                        if (err)                            end_sequence(ST_CMD16);
                        else if (e.wlo[12:9] != STATE_TRAN) end_sequence(ST_NOT_TRAN);
                        else next_cmd(CMD_APP, {rca, 16'h0000}, PH_B55);
                    end
                    PH_B55: begin
                        if (err) end_sequence(ST_ACMD6);
                        else     next_cmd(CMD_SWITCH, wide_cfg ? ARG_BUS_WIDE : 32'd0, PH_A6);
                    end
                    PH_A6: begin
                        if (err) end_sequence(ST_ACMD6);
                        else     next_cmd(CMD_SWITCH, ARG_Q6, PH_Q6);
                    end
                    PH_Q6: begin
                        if (err) end_sequence(ST_CMD6);
                        else     ph = PH_QDATA;
                    end
                    PH_S6: begin
                        if (err) end_sequence(ST_CMD6);
                        else     ph = PH_SDATA;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- driver and monitor

    // Note each accepted event transaction and predict its results
    always @(posedge i_clk) begin : accept_events
        t_event e;
        ev_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            e.kind = i_kind;
            e.tmo  = i_resp_timeout;
            e.crc  = i_resp_crc_error;
            e.wlo  = i_resp_word_low;
            e.whi  = i_resp_word_high;
            e.cnt  = i_block_word_count;
            sequence_step(e);
            items_left = items_left - 1;
        end
    end

    // Offer the next pending event once the current one has gone; hold it while stalled
    always @(negedge i_clk) begin : drive_events
        t_event e;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || ev_taken) begin
            if (hold_send || pending.size() == 0 || chance(send_gap_pct)) begin
                i_in_valid <= 1'b0;
            end else begin
                e = pending.pop_front();
                i_kind             <= e.kind;
                i_resp_timeout     <= e.tmo;
                i_resp_crc_error   <= e.crc;
                i_resp_word_low    <= e.wlo;
                i_resp_word_high   <= e.whi;
                i_block_word_count <= e.cnt;
                i_in_valid         <= 1'b1;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin : drive_stall
        i_out_stall <= chance(recv_gap_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            // concatenation follows the field order of t_result
            got = {o_cmd_valid, o_cmd_index, o_cmd_argument, o_divider_write, o_divider_value,
                   o_done_res, o_status, o_ver2_card, o_high_capacity, o_card_address,
                   o_last};
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing due, cmd_index", 32'(got.cmd_index),
                                32'd0);
            end else begin
                want = results_due.pop_front();
                check_field("cmd_valid", 32'(got.cmd_valid), 32'(want.cmd_valid));
                check_field("cmd_index", 32'(got.cmd_index), 32'(want.cmd_index));
                check_field("cmd_argument", got.cmd_argument, want.cmd_argument);
                check_field("divider_write", 32'(got.divider_write),
                            32'(want.divider_write));
                check_field("divider_value", 32'(got.divider_value),
                            32'(want.divider_value));
                check_field("done_res", 32'(got.done_res), 32'(want.done_res));
                check_field("status", 32'(got.status), 32'(want.status));
                check_field("ver2_card", 32'(got.ver2_card), 32'(want.ver2_card));
                check_field("high_capacity", 32'(got.high_capacity),
                            32'(want.high_capacity));
                check_field("card_address", 32'(got.card_address), 32'(want.card_address));
                check_field("last", 32'(got.last), 32'(want.last));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic t_event mk_event(logic [1:0] kind, logic tmo, logic crc,
                                        logic [31:0] wlo, logic [31:0] whi, logic [9:0] cnt);
        t_event e;
        e.kind = kind;
        e.tmo  = tmo;
        e.crc  = crc;
        e.wlo  = wlo;
        e.whi  = whi;
        e.cnt  = cnt;
        return e;
    endfunction

    function automatic t_event random_event(logic [1:0] kind);
        return mk_event(kind, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                        $urandom, 10'($urandom_range(1023)));
    endfunction

    task automatic push_event(t_event e);
        pending.push_back(e);
        items_left++;
        items_queued++;
    endtask

    // Push one step of a sequence, sometimes after an event of a kind it ignores
    task automatic queue_step(logic [1:0] kind, t_event e);
        logic [1:0] k;
        if (chance(8)) begin
            k = 2'($urandom_range(3));
            while (k == kind)
                k = 2'($urandom_range(3));
            push_event(random_event(k));
        end
        push_event(e);
    endtask

    // Push a command response, now and then with a timeout or CRC error
    task automatic queue_resp(input t_event e, input int fail_pct, output bit broke);
        logic [1:0] flags;
        broke = chance(fail_pct);
        flags = broke ? 2'($urandom_range(1, 3)) : 2'b00;
        e.tmo = flags[0];
        e.crc = flags[1];
        queue_step(KIND_RESP, e);
    endtask

    // Push one card bring-up, well formed unless a step is broken on purpose
    task automatic queue_bringup(int fail_pct);
        t_event     e;
        bit         broke;
        int         retries;
        logic [7:0] lim;
        queue_step(KIND_START, random_event(KIND_START));
        // CMD8: a CRC error ends the run, a bare timeout only clears the version 2 flag
        e     = random_event(KIND_RESP);
        e.crc = chance(fail_pct);
        e.tmo = e.crc ? e.tmo : chance(30);
        queue_step(KIND_RESP, e);
        if (e.crc)
            return;
        // power-up polling, sometimes until the try limit runs out
        lim = (tries_cfg == 8'd0) ? 8'd1 : tries_cfg;
        if (lim <= 8'd6 && chance(25))
            retries = int'(lim);
        else
            retries = $urandom_range((lim > 8'd3) ? 3 : int'(lim) - 1);
        for (int i = 0; i < retries; i++) begin
            queue_resp(random_event(KIND_RESP), fail_pct, broke);
            if (broke)
                return;
            e        = random_event(KIND_RESP);
            e.whi[7] = 1'b0;
            queue_resp(e, fail_pct, broke);
            if (broke || i + 1 >= lim)
                return;
        end
        queue_resp(random_event(KIND_RESP), fail_pct, broke);
        if (broke)
            return;
        e        = random_event(KIND_RESP);
        e.whi[7] = 1'b1;
        queue_resp(e, fail_pct, broke);
        if (broke)
            return;
        // CMD2, CMD3 and CMD7 take any words
        repeat (3) begin
            queue_resp(random_event(KIND_RESP), fail_pct, broke);
            if (broke)
                return;
        end
        // CMD16: the card must report the transfer state
        e = random_event(KIND_RESP);
        if (!chance(fail_pct))
            e.wlo[12:9] = STATE_TRAN;
        queue_resp(e, fail_pct, broke);
        if (broke || e.wlo[12:9] != STATE_TRAN)
            return;
        // CMD55, ACMD6 and the query CMD6
        repeat (3) begin
            queue_resp(random_event(KIND_RESP), fail_pct, broke);
            if (broke)
                return;
        end
        // query block, switch CMD6, switch block
        e = random_event(KIND_BLOCK);
        if (!chance(fail_pct))
            e.cnt = BLOCK_WORDS;
        queue_step(KIND_BLOCK, e);
        if (e.cnt != BLOCK_WORDS)
            return;
        queue_resp(random_event(KIND_RESP), fail_pct, broke);
        if (broke)
            return;
        e = random_event(KIND_BLOCK);
        if (!chance(fail_pct))
            e.cnt = BLOCK_WORDS;
        queue_step(KIND_BLOCK, e);
    endtask

    // Wait until every event is in and every result out, then let the pipeline settle
    task automatic wait_quiet();
        while (items_left != 0 || results_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Hold the sender until every expected result has arrived
    task automatic pause_sender();
        hold_send <= 1'b1;
        @(negedge i_clk);
        while (i_in_valid || results_due.size() != 0)
            @(negedge i_clk);
        hold_send <= 1'b0;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    // Write all four registers and mirror them in the predictor
    task automatic load_config(logic wide, logic [15:0] init_div, logic [15:0] run_div,
                               logic [7:0] tries);
        write_reg(CFG_WIDE_BUS, {15'd0, wide});
        write_reg(CFG_INIT_DIV, init_div);
        write_reg(CFG_RUN_DIV, run_div);
        write_reg(CFG_PU_TRIES, {8'd0, tries});
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        wide_cfg     = wide;
        init_div_cfg = init_div;
        run_div_cfg  = run_div;
        tries_cfg    = tries;
    endtask

    // Settle, reconfigure, then stream random bring-ups
    task automatic run_phase(int send_pct, int recv_pct, logic wide, logic [15:0] init_div,
                             logic [15:0] run_div, logic [7:0] tries);
        int goal;
        int nseq;
        wait_quiet();
        send_gap_pct <= send_pct;
        recv_gap_pct <= recv_pct;
        load_config(wide, init_div, run_div, tries);
        goal = items_queued + 130;
        nseq = 0;
        while (items_queued < goal) begin
            while (items_left > 4)
                @(negedge i_clk);
            if (nseq % 6 == 2)
                pause_sender();
            queue_bringup(4);
            nseq++;
        end
    endtask

    initial begin : stimulus
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle: unused kind, stray response and stray block are all dropped
        push_event(mk_event(KIND_UNUSED, 1'b1, 1'b1, '1, '1, '1));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        push_event(mk_event(KIND_BLOCK, 1'b0, 1'b0, '0, '0, BLOCK_WORDS));
        // start, then a second start while busy
        push_event(mk_event(KIND_START, 1'b0, 1'b0, '1, '1, '1));
        push_event(mk_event(KIND_START, 1'b0, 1'b0, '0, '0, '0));
        // CMD8 timeout alone: version 1 card, carry on
        push_event(mk_event(KIND_RESP, 1'b1, 1'b0, '0, '0, '0));
        // one power-up retry, then ready with large capacity
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '1, 32'hFFFF_FF7F, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '1, '0));
        // CMD2, then CMD3 with every address bit set
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '1, '1, '0));
        push_event(mk_event(KIND_BLOCK, 1'b0, 1'b0, '0, '0, BLOCK_WORDS));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        // CMD16 in transfer state, CMD55, ACMD6, query CMD6 gives no result
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, 32'h0000_0800, '0, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        // a response while awaiting data is dropped
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '1, '1, '1));
        push_event(mk_event(KIND_BLOCK, 1'b1, 1'b1, '1, '1, BLOCK_WORDS));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b0, '0, '0, '0));
        // short switch block fails the sequence
        push_event(mk_event(KIND_BLOCK, 1'b0, 1'b0, '0, '0, '1));
        // restart, then CMD8 CRC error
        push_event(mk_event(KIND_START, 1'b0, 1'b0, '0, '0, '0));
        push_event(mk_event(KIND_RESP, 1'b0, 1'b1, '0, '0, '0));

        run_phase(15, 69, 1'b1, 16'd0, 16'hFFFF, 8'd3);
        run_phase(69, 15, 1'b0, 16'hFFFF, 16'd0, 8'd1);
        run_phase(0, 0, 1'b1, 16'($urandom), 16'($urandom), 8'd0);
        run_phase(0, 0, 1'b0, 16'($urandom), 16'($urandom), 8'd255);
        wait_quiet();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
